// File: sv/rcb_pkg.sv
// Shared types and constants of the random cycle builder.
`default_nettype none

package rcb_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int NODE_W        = 10;
	localparam int COUNT_W       = 11;
	localparam int RAND_W        = 32;
	localparam int DIV_CNT_W     = $clog2(RAND_W);
	localparam int ADDR_W        = 3;
	localparam int DATA_W        = 32;

	localparam logic [63:0]        SEED_VALUE    = 64'h6a09e667f3bcc909;
	localparam int                 XS_SHIFT_A    = 13;
	localparam int                 XS_SHIFT_B    = 7;
	localparam int                 XS_SHIFT_C    = 17;
	localparam logic [COUNT_W-1:0] CYCLE_LEN_RST = 11'd1024;

	localparam logic OP_BUILD = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [ADDR_W-3:0] REG_CYCLE_LEN = 1'b0;

	typedef struct packed {
		logic              opcode;
		logic [NODE_W-1:0] node_index;
	} req_t;

	typedef struct packed {
		logic [NODE_W-1:0] next_node;
		logic              error;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic i_clr;
		logic i_top;
		logic i_inc;
		logic i_dec;
		logic fill_wr;
		logic draw;
		logic div_step;
		logic swap_rd;
		logic swap_wr_a;
		logic swap_wr_b;
		logic link_rd;
		logic link_wr;
		logic finish;
		logic lookup;
		logic rsp_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_idx;
		logic shuf_last;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// File: sv/rcb_ctrl.sv
// Sequencing state machine of the random cycle builder.
`default_nettype none

module rcb_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_stall,
	input  wire           opcode,
	input  rcb_pkg::sts_t sts,
	output rcb_pkg::cmd_t cmd
);
	import rcb_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FILL,
		S_DRAW,
		S_DIV,
		S_SWAP_RD,
		S_SWAP_WA,
		S_SWAP_WB,
		S_LINK_RD,
		S_LINK_WR,
		S_LOOKUP,
		S_RESP
	} state_t;

	state_t state_q;
	logic   stall_q;

	assign in_stall = stall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						stall_q <= 1'b1;
						state_q <= (opcode == OP_BUILD) ? S_FILL : S_LOOKUP;
					end
				end
				S_FILL: begin
					if (sts.last_idx) begin
						state_q <= S_DRAW;
					end
				end
				S_DRAW: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (sts.div_last) begin
						state_q <= S_SWAP_RD;
					end
				end
				S_SWAP_RD: begin
					state_q <= S_SWAP_WA;
				end
				S_SWAP_WA: begin
					state_q <= S_SWAP_WB;
				end
				S_SWAP_WB: begin
					state_q <= sts.shuf_last ? S_LINK_RD : S_DRAW;
				end
				S_LINK_RD: begin
					state_q <= S_LINK_WR;
				end
				S_LINK_WR: begin
					state_q <= sts.last_idx ? S_RESP : S_LINK_RD;
				end
				S_LOOKUP: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (sts.out_free) begin
						stall_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					stall_q <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				cmd.i_clr  = in_valid;
			end
			S_FILL: begin
				cmd.fill_wr = 1'b1;
				cmd.i_top   = sts.last_idx;
				cmd.i_inc   = !sts.last_idx;
			end
			S_DRAW: begin
				cmd.draw = 1'b1;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_SWAP_RD: begin
				cmd.swap_rd = 1'b1;
			end
			S_SWAP_WA: begin
				cmd.swap_wr_a = 1'b1;
			end
			S_SWAP_WB: begin
				cmd.swap_wr_b = 1'b1;
				cmd.i_clr     = sts.shuf_last;
				cmd.i_dec     = !sts.shuf_last;
			end
			S_LINK_RD: begin
				cmd.link_rd = 1'b1;
			end
			S_LINK_WR: begin
				cmd.link_wr = 1'b1;
				cmd.finish  = sts.last_idx;
				cmd.i_inc   = !sts.last_idx;
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
			end
			S_RESP: begin
				cmd.rsp_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsp_load |-> sts.out_free)
		else $error("response loaded while the output register is held");

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.fill_wr, cmd.swap_wr_a, cmd.swap_wr_b, cmd.link_wr}))
		else $error("more than one table write in a cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && sts.div_last) |=> (state_q == S_SWAP_RD))
		else $error("division did not hand over to the swap");

endmodule

`default_nettype wire

// File: sv/rcb_dp.sv
// Datapath of the random cycle builder: generator, divider, tables and output register.
`default_nettype none

module rcb_dp #(
	parameter int MAX_NODES = rcb_pkg::MAX_NODES_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  rcb_pkg::cmd_t                 cmd,
	output rcb_pkg::sts_t                 sts,
	input  wire [rcb_pkg::COUNT_W-1:0]    cycle_len,
	input  rcb_pkg::req_t                 req,
	output logic                          out_valid,
	input  wire                           out_stall,
	output rcb_pkg::rsp_t                 out_rsp
);
	import rcb_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);

	logic [NW-1:0] order_mem [MAX_NODES];
	logic [NW-1:0] succ_mem  [MAX_NODES];

	req_t           req_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  built_count_q;
	logic           built_q;
	logic [CW-1:0]  i_q;
	logic [63:0]    rng_q;
	logic [RAND_W-1:0]    dvd_q;
	logic [CW-1:0]        rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [NW-1:0]  order_a_q;
	logic [NW-1:0]  order_b_q;
	logic [NW-1:0]  succ_rd_q;
	logic           err_q;
	logic           out_valid_q;
	rsp_t           out_rsp_q;

	logic [31:0]   count_w;
	logic [31:0]   eff_w;
	logic [CW-1:0] i_plus1;
	logic [NW-1:0] nxt_idx;
	logic [CW:0]   rem_sh;
	logic [CW:0]   divisor;
	logic [63:0]   xs_a;
	logic [63:0]   xs_b;
	logic [63:0]   xs_c;
	logic [NW-1:0] ord_wr_addr;
	logic [NW-1:0] ord_wr_data;
	logic [NW-1:0] ord_rd_b_addr;

	// A build uses the register value clamped to the range two to the table depth.
	always_comb begin
		count_w = 32'(cycle_len);
		if (count_w < 32'd2) begin
			eff_w = 32'd2;
		end else if (count_w > 32'(MAX_NODES)) begin
			eff_w = 32'(MAX_NODES);
		end else begin
			eff_w = count_w;
		end
	end

	assign i_plus1 = i_q + CW'(1);
	assign nxt_idx = (i_plus1 == count_q) ? '0 : i_plus1[NW-1:0];

	assign xs_a = rng_q ^ (rng_q << XS_SHIFT_A);
	assign xs_b = xs_a ^ (xs_a >> XS_SHIFT_B);
	assign xs_c = xs_b ^ (xs_b << XS_SHIFT_C);

	// One restoring step of the remainder by i+1 per cycle.
	assign rem_sh  = {rem_q, dvd_q[RAND_W-1]};
	assign divisor = {1'b0, i_plus1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q         <= SEED_VALUE;
			built_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.draw) begin
				rng_q <= xs_c;
			end
			if (cmd.finish) begin
				built_q <= 1'b1;
			end
			if (cmd.rsp_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
			if (req.opcode == OP_BUILD) begin
				count_q <= eff_w[CW-1:0];
			end
		end
		if (cmd.finish) begin
			built_count_q <= count_q;
		end
		if (cmd.i_clr) begin
			i_q <= '0;
		end else if (cmd.i_top) begin
			i_q <= count_q - CW'(1);
		end else if (cmd.i_inc) begin
			i_q <= i_plus1;
		end else if (cmd.i_dec) begin
			i_q <= i_q - CW'(1);
		end
		if (cmd.draw) begin
			dvd_q     <= xs_c[63:64-RAND_W];
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q     <= dvd_q << 1;
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			if (rem_sh >= divisor) begin
				rem_q <= CW'(rem_sh - divisor);
			end else begin
				rem_q <= rem_sh[CW-1:0];
			end
		end
		if (cmd.lookup) begin
			err_q <= !built_q || (32'(req_q.node_index) >= 32'(built_count_q));
		end
		if (cmd.rsp_load) begin
			if (req_q.opcode == OP_BUILD || err_q) begin
				out_rsp_q.next_node <= '0;
			end else begin
				out_rsp_q.next_node <= NODE_W'(succ_rd_q);
			end
			out_rsp_q.error <= (req_q.opcode == OP_READ) && err_q;
		end
	end

	// Order table: one write port, two registered read ports.
	always_comb begin
		if (cmd.fill_wr || cmd.swap_wr_a) begin
			ord_wr_addr = i_q[NW-1:0];
		end else begin
			ord_wr_addr = rem_q[NW-1:0];
		end
		if (cmd.fill_wr) begin
			ord_wr_data = i_q[NW-1:0];
		end else if (cmd.swap_wr_a) begin
			ord_wr_data = order_b_q;
		end else begin
			ord_wr_data = order_a_q;
		end
		ord_rd_b_addr = cmd.link_rd ? nxt_idx : rem_q[NW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_wr || cmd.swap_wr_a || cmd.swap_wr_b) begin
			order_mem[ord_wr_addr] <= ord_wr_data;
		end
		if (cmd.swap_rd || cmd.link_rd) begin
			order_a_q <= order_mem[i_q[NW-1:0]];
			order_b_q <= order_mem[ord_rd_b_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.link_wr) begin
			succ_mem[order_a_q] <= order_b_q;
		end
		if (cmd.lookup) begin
			succ_rd_q <= succ_mem[NW'(req_q.node_index)];
		end
	end

	assign sts.last_idx  = (i_q == count_q - CW'(1));
	assign sts.shuf_last = (i_q == CW'(1));
	assign sts.div_last  = (div_cnt_q == DIV_CNT_W'(RAND_W - 1));
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		built_q |=> built_q)
		else $error("built flag dropped after a build");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> (rem_q <= i_q))
		else $error("partial remainder not below the divisor");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_rsp_q.error) |-> (out_rsp_q.next_node == '0))
		else $error("rejected read carries a non-zero successor");

endmodule

`default_nettype wire

// File: sv/random_cycle_builder.sv
// Random cycle builder: configuration register and controller/datapath pair.
//
// Requests enter on in_valid/in_stall with an in_req payload (opcode,
// node_index); one response per request leaves on out_valid/out_stall with
// out_rsp (next_node, error). A build request fills the order table with the
// identity, shuffles it from the top index down with draws from a 64-bit
// xorshift generator reduced modulo i+1, and links each node to the next.
// A build fills the table, then for each shuffled index makes one draw, forms
// the bit-serial remainder and swaps the pair through the single write port,
// then links the nodes and responds. A read request looks up the successor
// table in S_LOOKUP, and its response is loaded in S_RESP.
// One request is processed at a time; in_stall is high from acceptance until
// the response is loaded into the output register. The output register holds
// its response while out_stall is high, and a new request may be accepted
// while it waits. Reset clears the generator to its seed, forgets any built
// cycle (reads then report an error) and sets cycle_len to 1024. The user must
// write cycle_len (APB byte address 0) only while idle; it is not enforced.
`default_nettype none

module random_cycle_builder #(
	parameter int MAX_NODES = rcb_pkg::MAX_NODES_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  rcb_pkg::req_t               in_req,
	output logic                        out_valid,
	input  wire                         out_stall,
	output rcb_pkg::rsp_t               out_rsp,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [rcb_pkg::ADDR_W-1:0]   paddr,
	input  wire [rcb_pkg::DATA_W-1:0]   pwdata,
	output logic [rcb_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import rcb_pkg::*;

	logic [COUNT_W-1:0] cycle_len_q;
	logic               reg_sel;
	cmd_t               cmd;
	sts_t               sts;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_W-1:2] == REG_CYCLE_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_len_q <= CYCLE_LEN_RST;
		end else if (psel && penable && pwrite && reg_sel) begin
			cycle_len_q <= pwdata[COUNT_W-1:0];
		end
	end

	assign prdata = reg_sel ? DATA_W'(cycle_len_q) : '0;

	rcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (in_req.opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	rcb_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cycle_len  (cycle_len_q),
		.req        (in_req),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_rsp    (out_rsp)
	);

endmodule

`default_nettype wire

// File: tb/tb_random_cycle_builder.sv
`timescale 1ns / 100ps
// Self-checking testbench of the random cycle builder with its own shuffle model.
module tb_random_cycle_builder;
	import rcb_pkg::*;

	localparam int ITEM_TARGET = 1750;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_req = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsp_t out_rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	random_cycle_builder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_rsp(out_rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// Shadow copy of the block's tables, generator and register.
	logic [NODE_W-1:0] model_order [MAX_NODES_DEF];
	logic [NODE_W-1:0] model_succ [MAX_NODES_DEF];
	logic [63:0] rng_state = SEED_VALUE;
	logic have_cycle = 1'b0;
	int unsigned built_nodes = 0;
	logic [COUNT_W-1:0] cfg_cycle_len = CYCLE_LEN_RST;

	req_t req_backlog [$];
	rsp_t successor_answers [$];
	int unsigned queued_items = 0;
	int mismatches = 0;
	int gap_left = 0;
	int send_calm = 0;
	int stall_left = 0;
	int stall_calm = 0;

	function automatic int unsigned clamp_count(logic [COUNT_W-1:0] c);
		if (c < 2)
			return 2;
		if (c > MAX_NODES_DEF)
			return MAX_NODES_DEF;
		return c;
	endfunction

	function automatic logic [31:0] xorshift_draw();
		logic [63:0] v;
		v = rng_state;
		v ^= v << XS_SHIFT_A;
		v ^= v >> XS_SHIFT_B;
		v ^= v << XS_SHIFT_C;
		rng_state = v;
		return v[63:32];
	endfunction

	function automatic void build_shuffled_cycle();
		int unsigned cnt;
		int unsigned j;
		logic [NODE_W-1:0] t;
		cnt = clamp_count(cfg_cycle_len);
		for (int unsigned k = 0; k < cnt; k++)
			model_order[k] = NODE_W'(k);
		for (int i = cnt - 1; i > 0; i--) begin
			j = xorshift_draw() % $unsigned(i + 1);
			t = model_order[i];
			model_order[i] = model_order[j];
			model_order[j] = t;
		end
		for (int unsigned k = 0; k < cnt; k++)
			model_succ[model_order[k]] = model_order[(k + 1 == cnt) ? 0 : k + 1];
		built_nodes = cnt;
		have_cycle = 1'b1;
	endfunction

	function automatic rsp_t predict_response(req_t r);
		rsp_t p;
		p = '0;
		if (r.opcode == OP_BUILD)
			build_shuffled_cycle();
		else if (!have_cycle || r.node_index >= built_nodes)
			p.error = 1'b1;
		else
			p.next_node = model_succ[r.node_index];
		return p;
	endfunction

	// Mostly short idle spells, a few long ones, and now and then a calm stretch with none.
	function automatic int pick_idle(ref int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic void queue_request(logic op, int unsigned idx);
		req_t r;
		r.opcode = op;
		r.node_index = NODE_W'(idx);
		req_backlog.push_back(r);
		queued_items++;
	endfunction

	task automatic wait_idle();
		while (req_backlog.size() != 0 || in_valid || successor_answers.size() != 0)
			@(negedge clk);
	endtask

	// Write the count register, then read it back.
	task automatic write_cycle_len(logic [COUNT_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_CYCLE_LEN, 2'b00};
		pwdata <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== DATA_W'(value)) begin
			$display("%0t: cycle_len readback expected %0d got %0d", $time, value, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		cfg_cycle_len = value;
	endtask

	// Request driver: the expectation is formed at the edge that accepts the request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				successor_answers.push_back(predict_response(in_req));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (req_backlog.size() != 0) begin
					in_req <= req_backlog.pop_front();
					in_valid <= 1'b1;
					gap_left = pick_idle(send_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor and back-pressure.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (successor_answers.size() == 0) begin
					$display("%0t: unexpected response next_node=%0d error=%0b",
						$time, out_rsp.next_node, out_rsp.error);
					mismatches++;
				end else begin
					want = successor_answers.pop_front();
					if (out_rsp.next_node !== want.next_node) begin
						$display("%0t: next_node expected %0d got %0d",
							$time, want.next_node, out_rsp.next_node);
						mismatches++;
					end
					if (out_rsp.error !== want.error) begin
						$display("%0t: error expected %0b got %0b",
							$time, want.error, out_rsp.error);
						mismatches++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = pick_idle(stall_calm);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int unsigned eff;
		int unsigned n;
		int unsigned r;
		int unsigned phase;
		logic [COUNT_W-1:0] cnt;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Nothing has been built yet, so both reads must be rejected.
		queue_request(OP_READ, 0);
		queue_request(OP_READ, 1023);
		queue_request(OP_BUILD, 0);
		queue_request(OP_READ, 0);
		queue_request(OP_READ, 1023);
		queue_request(OP_READ, 512);
		wait_idle();
		// Counts of zero and one behave as two.
		write_cycle_len(0);
		queue_request(OP_BUILD, 1023);
		queue_request(OP_READ, 0);
		queue_request(OP_READ, 1);
		queue_request(OP_READ, 2);
		queue_request(OP_READ, 1023);
		wait_idle();
		write_cycle_len(1);
		queue_request(OP_BUILD, 0);
		queue_request(OP_READ, 1);
		queue_request(OP_READ, 2);
		wait_idle();
		// The all-ones count saturates to the full table.
		write_cycle_len(2047);
		queue_request(OP_BUILD, 1023);
		queue_request(OP_READ, 1023);
		queue_request(OP_READ, 700);
		wait_idle();
		write_cycle_len(3);
		queue_request(OP_BUILD, 0);
		wait_idle();
		// Reads are bounded by the last build, not by the register as it now stands.
		write_cycle_len(1024);
		queue_request(OP_READ, 3);
		queue_request(OP_READ, 2);
		queue_request(OP_READ, 0);
		wait_idle();

		phase = 0;
		while (queued_items < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (phase == 20)
				cnt = 1024;
			else if (phase == 60)
				cnt = $urandom_range(1025, 2047);
			else if (r < 70)
				cnt = $urandom_range(0, 16);
			else if (r < 92)
				cnt = $urandom_range(17, 100);
			else
				cnt = $urandom_range(101, 300);
			if (phase == 20 || phase == 60 || $urandom_range(0, 3) != 0)
				write_cycle_len(cnt);
			// Sometimes probe the previous cycle before rebuilding.
			if ($urandom_range(0, 9) < 3)
				repeat ($urandom_range(2, 5))
					queue_request(OP_READ, $urandom_range(0, built_nodes));
			queue_request(OP_BUILD, $urandom_range(0, 1023));
			eff = clamp_count(cfg_cycle_len);
			n = $urandom_range(4, 24);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 80)
					queue_request(OP_READ, $urandom_range(0, eff - 1));
				else if (r < 90)
					queue_request(OP_READ, $urandom_range(0, 1023));
				else if (r < 96)
					queue_request(OP_READ, (eff < MAX_NODES_DEF) ? eff : 1023);
				else
					queue_request(OP_BUILD, $urandom_range(0, 1023));
			end
			wait_idle();
			phase++;
		end

		wait_idle();
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("tb_random_cycle_builder: clean");
		else
			$display("tb_random_cycle_builder: errors");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb_random_cycle_builder: errors");
		$finish;
	end

endmodule

// File: filelist.f
sv/rcb_pkg.sv
sv/rcb_ctrl.sv
sv/rcb_dp.sv
sv/random_cycle_builder.sv
tb/tb_random_cycle_builder.sv
